>>> design/srp_pkg.sv
// Shared types and constants for the schedule record parser.
// No dependencies; imported by every module of the block.
package srp_pkg;

  localparam int unsigned MAX_FIELD_LENGTH = 255;
  localparam int unsigned NAME_INDEX_BITS  = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TDATA_W = 112;
  localparam int unsigned TUSER_W = 3;

  localparam logic [7:0] MaxLen = 8'(MAX_FIELD_LENGTH);
  localparam logic [15:0] NameLimit = (NAME_INDEX_BITS >= 16) ? 16'hFFFF :
                                      16'((64'd1 << NAME_INDEX_BITS) - 64'd1);

  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  localparam logic [2:0] ColName     = 3'd1;
  localparam logic [2:0] ColBurst    = 3'd2;
  localparam logic [2:0] ColArrival  = 3'd3;
  localparam logic [2:0] ColPriority = 3'd4;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_EMPTY = 3'd1,
    ERR_CHAR  = 3'd2,
    ERR_LONG  = 3'd3,
    ERR_COLS  = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    CLS_SPACE   = 3'd0,
    CLS_NEWLINE = 3'd1,
    CLS_COMMA   = 3'd2,
    CLS_DIGIT   = 3'd3,
    CLS_MINUS   = 3'd4,
    CLS_OTHER   = 3'd5
  } cls_e;

  // One classified character waiting for the back end
  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic       file_start;
  } token_t;

  typedef struct packed {
    logic [15:0] name_index;
    logic [31:0] burst_value;
    logic [31:0] arrival_value;
    logic [31:0] priority_value;
    err_e        error_code;
  } record_t;

endpackage

>>> design/srp_front.sv
// Front end: classifies each incoming character into a token.
// Depends on srp_pkg.
module srp_front (
  input  logic            in_valid_i,
  input  logic [7:0]      text_byte_i,
  input  logic            file_start_i,
  output logic            push_o,
  output srp_pkg::token_t token_o
);
  import srp_pkg::*;

  logic [7:0] diff;

  assign diff = text_byte_i - ChZero;

  always_comb begin
    token_o.file_start = file_start_i;
    token_o.digit      = diff[3:0];
    if (text_byte_i == ChSpace) begin
      token_o.cls = CLS_SPACE;
    end else if (text_byte_i == ChNewline) begin
      token_o.cls = CLS_NEWLINE;
    end else if (text_byte_i == ChComma) begin
      token_o.cls = CLS_COMMA;
    end else if (text_byte_i >= ChZero && text_byte_i <= ChNine) begin
      token_o.cls = CLS_DIGIT;
    end else if (text_byte_i == ChMinus) begin
      token_o.cls = CLS_MINUS;
    end else begin
      token_o.cls = CLS_OTHER;
    end
  end

  // A plain space changes nothing; only keep it when it carries a file start
  assign push_o = in_valid_i && (token_o.cls != CLS_SPACE || file_start_i);

endmodule

>>> design/srp_queue.sv
// Small token FIFO between the front and back ends.
// Depends on srp_pkg.
module srp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  srp_pkg::token_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            rd_valid_o,
  output srp_pkg::token_t rd_data_o
);
  import srp_pkg::*;

  token_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_wr, do_rd;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
      if (do_rd) rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rd_valid_o && !do_wr) |=> !rd_valid_o)
    else $error("queue produced data without a write");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a write");

endmodule

>>> design/srp_back.sv
// Back end: parser state, field accumulation, error detection, output register.
// Depends on srp_pkg.
module srp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  srp_pkg::token_t  tok_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srp_pkg::record_t out_o
);
  import srp_pkg::*;

  logic [2:0]  col_q, col_d, col_e;
  logic [7:0]  len_q, len_d, len_e;
  logic [31:0] val_q, val_d, val_e;
  logic        minus_q, minus_d, minus_e;
  logic [15:0] cnt_q, cnt_d, cnt_e;
  logic [15:0] hname_q, hname_d, hname_e;
  logic [31:0] hburst_q, hburst_d, hburst_e;
  logic [31:0] harr_q, harr_d, harr_e;
  logic        halt_q, halt_d, halt_e;

  logic        out_valid_q;
  record_t     out_q;
  logic        emit;
  record_t     rec;
  logic [31:0] field_res;
  logic        fail;
  err_e        fail_code;

  assign pop_o = tok_valid_i && (!out_valid_q || out_ready_i);

  // File start clears the state before the character is handled
  always_comb begin
    if (tok_i.file_start) begin
      col_e = ColName;  len_e = '0;  val_e = '0;  minus_e = 1'b0;
      cnt_e = '0;  hname_e = '0;  hburst_e = '0;  harr_e = '0;  halt_e = 1'b0;
    end else begin
      col_e = col_q;  len_e = len_q;  val_e = val_q;  minus_e = minus_q;
      cnt_e = cnt_q;  hname_e = hname_q;  hburst_e = hburst_q;  harr_e = harr_q;
      halt_e = halt_q;
    end
  end

  assign field_res = minus_e ? (32'd0 - val_e) : val_e;

  always_comb begin
    col_d = col_e;  len_d = len_e;  val_d = val_e;  minus_d = minus_e;
    cnt_d = cnt_e;  hname_d = hname_e;  hburst_d = hburst_e;  harr_d = harr_e;
    halt_d    = halt_e;
    emit      = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    rec       = '0;

    if (!halt_e) begin
      unique case (tok_i.cls)
        CLS_SPACE: begin
        end
        CLS_NEWLINE: begin
          if (col_e != ColPriority) begin
            fail = 1'b1;  fail_code = ERR_COLS;
          end else if (len_e == '0) begin
            fail = 1'b1;  fail_code = ERR_EMPTY;
          end else begin
            emit               = 1'b1;
            rec.name_index     = hname_e;
            rec.burst_value    = hburst_e;
            rec.arrival_value  = harr_e;
            rec.priority_value = field_res;
            rec.error_code     = ERR_NONE;
            len_d = '0;  val_d = '0;  minus_d = 1'b0;
            col_d = ColName;
            hname_d = '0;  hburst_d = '0;  harr_d = '0;
          end
        end
        CLS_COMMA: begin
          if (col_e == ColName) begin
            if (len_e >= MaxLen) begin
              fail = 1'b1;  fail_code = ERR_LONG;
            end else begin
              hname_d = cnt_e;
              if (cnt_e < NameLimit) cnt_d = cnt_e + 16'd1;
            end
          end else if (len_e == '0) begin
            fail = 1'b1;  fail_code = ERR_EMPTY;
          end else if (col_e == ColBurst) begin
            hburst_d = field_res;
          end else if (col_e == ColArrival) begin
            harr_d = field_res;
          end else begin
            fail = 1'b1;  fail_code = ERR_COLS;
          end
          if (!fail) begin
            len_d = '0;  val_d = '0;  minus_d = 1'b0;
            col_d = col_e + 3'd1;
          end
        end
        default: begin
          if (len_e >= MaxLen) begin
            fail = 1'b1;  fail_code = ERR_LONG;
          end else if (col_e != ColName) begin
            if (tok_i.cls == CLS_DIGIT) begin
              // times ten as two shifts and an add
              val_d = (val_e << 3) + (val_e << 1) + {28'd0, tok_i.digit};
            end else if (tok_i.cls == CLS_MINUS && len_e == '0) begin
              minus_d = 1'b1;
            end else begin
              fail = 1'b1;  fail_code = ERR_CHAR;
            end
          end
          if (!fail) len_d = len_e + 8'd1;
        end
      endcase

      if (fail) begin
        halt_d = 1'b1;
        emit   = 1'b1;
        rec    = '0;
        rec.error_code = fail_code;
        // state other than the halt flag stays as it was
        col_d = col_e;  len_d = len_e;  val_d = val_e;  minus_d = minus_e;
        cnt_d = cnt_e;  hname_d = hname_e;  hburst_d = hburst_e;  harr_d = harr_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= ColName;  len_q <= '0;  val_q <= '0;  minus_q <= 1'b0;
      cnt_q <= '0;  hname_q <= '0;  hburst_q <= '0;  harr_q <= '0;
      halt_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        col_q <= col_d;  len_q <= len_d;  val_q <= val_d;  minus_q <= minus_d;
        cnt_q <= cnt_d;  hname_q <= hname_d;  hburst_q <= hburst_d;
        harr_q <= harr_d;  halt_q <= halt_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) out_q <= rec;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error_code != ERR_NONE) |->
      (out_q.name_index == '0 && out_q.burst_value == '0 &&
       out_q.arrival_value == '0 && out_q.priority_value == '0))
    else $error("error record carries field data");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q >= ColName && col_q <= ColPriority)
    else $error("column number out of range");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && halt_q && !tok_i.file_start && !out_valid_q) |=> !out_valid_q)
    else $error("result emitted while halted");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_q && !(pop_o && tok_i.file_start)) |=> halt_q)
    else $error("halt cleared without file start");

endmodule

>>> design/schedule_record_parser_core.sv
// Schedule record parser, top level: front classifier, token queue, back end.
// Depends on srp_pkg, srp_front, srp_queue, srp_back.
//
// Usage:
//   Input stream (s_axis_*): one character of a comma-separated process file
//   per transaction, lines of the form name,burst,arrival,priority. tuser set
//   clears all parser state before that character is handled.
//   Output stream (m_axis_*): one record per completed line, or one error
//   record (all data zero, nonzero code in tuser) after which the parser
//   ignores input until the next file start.
//   Throughput: one character per cycle while the receiver keeps up; the
//   four-entry token queue and the output register let the sender stall
//   freely and absorb a receiver stall. Record path: a newline is queued when
//   accepted; its record loads into the output register once that is free.
//   Spaces without file start are dropped in the front end and never queued.
//   Reset: the queue empties, the output register goes invalid and the parser
//   returns to the first column with the name counter at zero.
//   Receiver stall: the output register holds its record; the back end stops
//   popping, the queue fills, and s_axis_tready drops once it is full.
module schedule_record_parser_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] text_byte
  input  logic                         s_axis_tuser,  // [0] file_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] name_index, [47:16] burst_value, [79:48] arrival_value,
  // [111:80] priority_value
  output logic [srp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic [srp_pkg::TUSER_W-1:0]  m_axis_tuser  // [2:0] error_code
);
  import srp_pkg::*;

  token_t  front_tok, q_tok;
  logic    front_push, q_full, q_valid, back_pop;
  record_t rec;

  assign s_axis_tready = !q_full;

  srp_front u_front (
    .in_valid_i   (s_axis_tvalid && !q_full),
    .text_byte_i  (s_axis_tdata),
    .file_start_i (s_axis_tuser),
    .push_o       (front_push),
    .token_o      (front_tok)
  );

  srp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (front_push),
    .wr_data_i  (front_tok),
    .full_o     (q_full),
    .rd_i       (back_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_tok)
  );

  srp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .pop_o       (back_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (rec)
  );

  assign m_axis_tdata = {rec.priority_value, rec.arrival_value,
                         rec.burst_value, rec.name_index};
  assign m_axis_tuser = rec.error_code;

endmodule
